FILE: hw/rtl/evr_pkg.sv
// Package with the types, constants and divider step shared by the event record encoder.
`default_nettype none

package evr_pkg;

    localparam int TICK_W       = 48;
    localparam int SECONDS_W    = 42;
    localparam int MICROS_W     = 20;
    localparam int REM_W        = 7;
    localparam int DIGIT_W      = 6;
    localparam int DIV_STAGES   = TICK_W / DIGIT_W;
    localparam int TICKS_PER_SEC = 100;
    localparam int MICROS_PER_TICK = 10000;

    localparam int IN_TDATA_W   = 112;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 88;
    localparam int REC_TYPE_W   = 3;
    localparam int REC_CODE_W   = 9;
    localparam int REC_VALUE_W  = 16;

    localparam int NUM_BUTTONS  = 5;
    localparam int BTN_IDX_W    = $clog2(NUM_BUTTONS);

    localparam logic [IN_TUSER_W-1:0] KIND_KEY   = 2'd0;
    localparam logic [IN_TUSER_W-1:0] KIND_MOUSE = 2'd1;

    localparam logic [REC_TYPE_W-1:0] TYPE_SYN = 3'd0;
    localparam logic [REC_TYPE_W-1:0] TYPE_KEY = 3'd1;
    localparam logic [REC_TYPE_W-1:0] TYPE_REL = 3'd2;
    localparam logic [REC_TYPE_W-1:0] TYPE_MSC = 3'd4;

    localparam logic [REC_CODE_W-1:0] CODE_SCAN   = 9'h004;
    localparam logic [REC_CODE_W-1:0] CODE_RX     = 9'h000;
    localparam logic [REC_CODE_W-1:0] CODE_RY     = 9'h001;
    localparam logic [REC_CODE_W-1:0] CODE_WHEEL  = 9'h008;
    localparam logic [REC_CODE_W-1:0] CODE_SYN    = 9'h000;
    localparam logic [REC_CODE_W-1:0] BUTTON_BASE = 9'h110;

    // Record slots of a burst, in emission order.
    localparam int REC_SCAN  = 0;
    localparam int REC_KEY   = 1;
    localparam int REC_RX    = 2;
    localparam int REC_RY    = 3;
    localparam int REC_WHEEL = 4;
    localparam int REC_BTN0  = 5;
    localparam int REC_SYNC  = REC_BTN0 + NUM_BUTTONS;
    localparam int NUM_REC   = REC_SYNC + 1;

    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    typedef struct packed {
        logic [1:0]             pad;
        logic [TICK_W-1:0]      tick;
        logic [NUM_BUTTONS-1:0] buttons;
        logic [15:0]            dz;
        logic [15:0]            dy;
        logic [15:0]            dx;
        logic                   released;
        logic [7:0]             scan;
    } in_item_t;

    typedef struct packed {
        logic                   pad;
        logic [REC_VALUE_W-1:0] value;
        logic [REC_CODE_W-1:0]  code;
        logic [MICROS_W-1:0]    micros;
        logic [SECONDS_W-1:0]   seconds;
    } record_t;

    typedef struct packed {
        logic [NUM_REC-1:0]     mask;
        logic [6:0]             scan;
        logic                   pressed;
        logic [15:0]            dx;
        logic [15:0]            dy;
        logic [15:0]            dz;
        logic [NUM_BUTTONS-1:0] buttons;
    } desc_t;

    typedef struct packed {
        desc_t              desc;
        logic [REM_W-1:0]   rem;
        logic [TICK_W-1:0]  quo;
        logic [TICK_W-1:0]  tick;
    } stage_t;

    typedef struct packed {
        desc_t                desc;
        logic [REM_W-1:0]     rem;
        logic [SECONDS_W-1:0] seconds;
    } burst_t;

    localparam int STEP_W = REM_W + DIGIT_W;

    // One radix-64 digit of the long division by the tick rate.
    function automatic stage_t div_step(input stage_t s);
        stage_t            r;
        logic [STEP_W-1:0] v;
        logic [DIGIT_W-1:0] d;
        r = s;
        v = {s.rem, s.tick[TICK_W-1 -: DIGIT_W]};
        d = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            if (v >= (STEP_W'(TICKS_PER_SEC) << i)) begin
                v = v - (STEP_W'(TICKS_PER_SEC) << i);
                d[i] = 1'b1;
            end
        end
        r.rem  = v[REM_W-1:0];
        r.quo  = {s.quo[TICK_W-DIGIT_W-1:0], d};
        r.tick = {s.tick[TICK_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/input_event_to_evdev_records_unit.sv
// Top level of the encoder that turns keyboard and mouse events into timestamped records.
// An event passes the divider stages, the queue and the back end's burst and output
// registers before its first record is offered. One event per cycle enters the eight-stage
// stamp divider unless a full queue holds it; the record port then sets the pace at one
// record per cycle while m_axis_tready is high, at most three per key and nine per mouse event.
// Reset clears all valid flags and the stored button state; no clearing pass is needed.
`default_nettype none

module input_event_to_evdev_records_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // scan_byte, released, delta_x, delta_y, delta_wheel, button_bits, tick_count
    input  wire logic [evr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic [evr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // stamp_seconds, stamp_micros, record_code, record_value
    output logic [evr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // record_type
    output logic [evr_pkg::REC_TYPE_W-1:0]       m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import evr_pkg::*;

    logic   wr_valid;
    logic   wr_ready;
    burst_t wr_data;
    logic   rd_valid;
    logic   rd_ready;
    burst_t rd_data;

    evr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (wr_valid),
        .q_ready       (wr_ready),
        .q_data        (wr_data)
    );

    evr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data)
    );

    evr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rd_valid      (rd_valid),
        .rd_ready      (rd_ready),
        .rd_data       (rd_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/evr_front.sv
// Front end: accepts events, classifies them into record slots and divides the tick stamp.
`default_nettype none

module evr_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [evr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [evr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                                 q_valid,
    input  wire logic                            q_ready,
    output evr_pkg::burst_t                      q_data
);
    import evr_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    in_item_t               item;
    desc_t                  in_desc;
    logic [NUM_BUTTONS-1:0] changed;
    logic                   accept;
    logic [NUM_BUTTONS-1:0] prev_buttons_reg;
    logic [NUM_BUTTONS-1:0] prev_buttons_next;

    stage_t                 stage_reg [DIV_STAGES];
    stage_t                 step_in [DIV_STAGES];
    logic [DIV_STAGES-1:0]  stage_valid_reg;
    logic [DIV_STAGES-1:0]  stage_valid_next;
    logic [DIV_STAGES-1:0]  take;
    logic [DIV_STAGES-1:0]  load;
    logic                   last_empty;

    assign item = s_axis_tdata;

    always_comb begin
        changed = item.buttons ^ prev_buttons_reg;
        in_desc = '0;
        in_desc.scan    = item.scan[6:0];
        in_desc.pressed = ~item.released;
        in_desc.dx      = item.dx;
        in_desc.dy      = item.dy;
        in_desc.dz      = item.dz;
        in_desc.buttons = item.buttons;
        unique case (s_axis_tuser)
            KIND_KEY: begin
                in_desc.mask[REC_SCAN] = (item.scan[6:0] != 7'd0);
                in_desc.mask[REC_KEY]  = (item.scan[6:0] != 7'd0);
            end
            KIND_MOUSE: begin
                in_desc.mask[REC_RX]    = (item.dx != 16'd0);
                in_desc.mask[REC_RY]    = (item.dy != 16'd0);
                in_desc.mask[REC_WHEEL] = (item.dz != 16'd0);
                in_desc.mask[REC_BTN0 +: NUM_BUTTONS] = changed;
            end
            default: begin
            end
        endcase
        in_desc.mask[REC_SYNC] = |in_desc.mask[REC_SYNC-1:0];
    end

    assign accept = s_axis_tvalid && s_axis_tready;
    assign prev_buttons_next = (accept && (s_axis_tuser == KIND_MOUSE)) ? item.buttons
                                                                        : prev_buttons_reg;

    assign last_empty = (stage_reg[LAST].desc.mask == '0);

    always_comb begin
        take[LAST] = q_ready || last_empty;
        for (int j = DIV_STAGES - 2; j >= 0; j--) begin
            take[j] = !stage_valid_reg[j+1] || take[j+1];
        end
        s_axis_tready = !stage_valid_reg[0] || take[0];
        load[0] = accept;
        for (int j = 1; j < DIV_STAGES; j++) begin
            load[j] = stage_valid_reg[j-1] && take[j-1];
        end
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (load[j]) begin
                stage_valid_next[j] = 1'b1;
            end else if (take[j]) begin
                stage_valid_next[j] = 1'b0;
            end else begin
                stage_valid_next[j] = stage_valid_reg[j];
            end
        end
    end

    always_comb begin
        step_in[0].desc = in_desc;
        step_in[0].rem  = '0;
        step_in[0].quo  = '0;
        step_in[0].tick = item.tick;
        for (int j = 1; j < DIV_STAGES; j++) begin
            step_in[j] = stage_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg  <= '0;
            prev_buttons_reg <= '0;
        end else begin
            stage_valid_reg  <= stage_valid_next;
            prev_buttons_reg <= prev_buttons_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (load[j]) begin
                stage_reg[j] <= div_step(step_in[j]);
            end
        end
    end

    assign q_valid         = stage_valid_reg[LAST] && !last_empty;
    assign q_data.desc     = stage_reg[LAST].desc;
    assign q_data.rem      = stage_reg[LAST].rem;
    assign q_data.seconds  = stage_reg[LAST].quo[SECONDS_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/evr_queue.sv
// Short queue of classified bursts between the front end and the record sequencer.
`default_nettype none

module evr_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire evr_pkg::burst_t wr_data,
    output logic                 rd_valid,
    input  wire logic            rd_ready,
    output evr_pkg::burst_t      rd_data
);
    import evr_pkg::*;

    burst_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                push;
    logic                pop;

    assign wr_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/evr_back.sv
// Back end: walks the record slots of each burst and drives one record per transaction.
`default_nettype none

module evr_back (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             rd_valid,
    output logic                                  rd_ready,
    input  wire evr_pkg::burst_t                  rd_data,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [evr_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic [evr_pkg::REC_TYPE_W-1:0]        m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import evr_pkg::*;

    burst_t                  cur_reg;
    logic                    cur_valid_reg;
    logic                    cur_valid_next;
    logic [NUM_REC-1:0]      pend_reg;
    logic [NUM_REC-1:0]      lowest;
    logic [NUM_REC-1:0]      pend_left;
    logic [BTN_IDX_W-1:0]    btn_idx;
    logic                    out_free;
    logic                    emit;
    logic                    fetch;

    record_t                 rec;
    logic [REC_TYPE_W-1:0]   rec_type;
    record_t                 out_rec_reg;
    logic [REC_TYPE_W-1:0]   out_type_reg;
    logic                    out_last_reg;
    logic                    m_valid_reg;
    logic                    m_valid_next;

    assign lowest    = pend_reg & (~pend_reg + 1'b1);
    assign pend_left = pend_reg & ~lowest;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign emit      = cur_valid_reg && out_free;
    assign rd_ready  = !cur_valid_reg || (emit && (pend_left == '0));
    assign fetch     = rd_valid && rd_ready;

    always_comb begin
        cur_valid_next = rd_ready ? rd_valid : cur_valid_reg;
        m_valid_next   = emit ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
    end

    always_comb begin
        btn_idx = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (pend_reg[REC_BTN0 + i]) begin
                btn_idx = BTN_IDX_W'(i);
            end
        end
    end

    always_comb begin
        rec.pad     = 1'b0;
        rec.seconds = cur_reg.seconds;
        rec.micros  = MICROS_W'(cur_reg.rem) * MICROS_W'(MICROS_PER_TICK);
        priority if (pend_reg[REC_SCAN]) begin
            rec_type  = TYPE_MSC;
            rec.code  = CODE_SCAN;
            rec.value = REC_VALUE_W'(cur_reg.desc.scan);
        end else if (pend_reg[REC_KEY]) begin
            rec_type  = TYPE_KEY;
            rec.code  = REC_CODE_W'(cur_reg.desc.scan);
            rec.value = REC_VALUE_W'(cur_reg.desc.pressed);
        end else if (pend_reg[REC_RX]) begin
            rec_type  = TYPE_REL;
            rec.code  = CODE_RX;
            rec.value = cur_reg.desc.dx;
        end else if (pend_reg[REC_RY]) begin
            rec_type  = TYPE_REL;
            rec.code  = CODE_RY;
            rec.value = cur_reg.desc.dy;
        end else if (pend_reg[REC_WHEEL]) begin
            rec_type  = TYPE_REL;
            rec.code  = CODE_WHEEL;
            rec.value = cur_reg.desc.dz;
        end else if (|pend_reg[REC_BTN0 +: NUM_BUTTONS]) begin
            rec_type  = TYPE_KEY;
            rec.code  = BUTTON_BASE + REC_CODE_W'(btn_idx);
            rec.value = REC_VALUE_W'(cur_reg.desc.buttons[btn_idx]);
        end else begin
            rec_type  = TYPE_SYN;
            rec.code  = CODE_SYN;
            rec.value = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fetch) begin
            cur_reg  <= rd_data;
            pend_reg <= rd_data.desc.mask;
        end else if (emit) begin
            pend_reg <= pend_left;
        end
        if (emit) begin
            out_rec_reg  <= rec;
            out_type_reg <= rec_type;
            out_last_reg <= (pend_left == '0);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_rec_reg;
    assign m_axis_tuser  = out_type_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/evr_checker.sv
// Port-level assertions for the event record encoder and the bind that attaches them.
`default_nettype none

module evr_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [evr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [evr_pkg::REC_TYPE_W-1:0]  m_axis_tuser,
    input  wire logic                            m_axis_tlast
);
    import evr_pkg::*;

    record_t out_rec;
    assign out_rec = m_axis_tdata;

    // The closing transaction of a burst is a sync record and only it is.
    a_last_is_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((m_axis_tuser == TYPE_SYN) == m_axis_tlast))
        else $error("last flag and sync type disagree");

    a_sync_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> (out_rec.code == CODE_SYN && out_rec.value == '0))
        else $error("sync record carries a code or value");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled record changed");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("record offered right after reset");

endmodule

bind input_event_to_evdev_records_unit evr_checker u_evr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
